>>> rtl/lfsb_pkg.sv
// Shared types and constants for the LED frame stream builder.
package lfsb_pkg;

  typedef enum logic [1:0] {
    CMD_SET_ONE = 2'd0,
    CMD_SET_ALL = 2'd1,
    CMD_FETCH   = 2'd2
  } cmd_t;

  typedef enum logic {
    CFG_LED_COUNT      = 1'b0,
    CFG_STOP_ZERO_BITS = 1'b1
  } cfg_index_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  localparam int ENTRY_W    = 29;
  localparam int WORD_W     = 32;
  localparam int CFG_DATA_W = 9;

  // Header mark bits placed above the stored brightness.
  localparam logic [2:0] HDR_MARK = 3'b111;

  typedef enum logic [1:0] {
    WSEL_ZERO = 2'd0,
    WSEL_ONES = 2'd1,
    WSEL_MEM  = 2'd2
  } word_sel_t;

  typedef struct packed {
    word_sel_t sel;
    logic      last;
  } word_info_t;

endpackage

>>> rtl/lfsb_in_if.sv
// Input channel: command items with LED payload.
interface lfsb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] led_index;
  logic [4:0] brightness;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, cmd, led_index, brightness, blue, green, red, input ready);
  modport sink (input valid, cmd, led_index, brightness, blue, green, red, output ready);
endinterface

>>> rtl/lfsb_out_if.sv
// Output channel: status and stream word items.
interface lfsb_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] stream_word;
  logic        last_word;

  modport source (output valid, status, stream_word, last_word, input ready);
  modport sink (input valid, status, stream_word, last_word, output ready);
endinterface

>>> rtl/led_frame_stream_builder.sv
// Top level of the LED frame stream builder: frame memory, sequencer and output stage.
// Set-one and fetch items are taken one per cycle while the output does not stall.
// An item waits in a pending stage while the frame memory's registered read port
// delivers the fetch word, then moves to the output register once that is free. A set-all
// item holds off the input while the single memory write port sweeps the first led_count
// entries (led_count saturated to MAX_LEDS). After reset a clearing pass zeroes all
// MAX_LEDS entries, and no item is accepted until it ends; configuration writes are
// taken at any time.
module led_frame_stream_builder #(
  parameter int MAX_LEDS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [lfsb_pkg::CFG_DATA_W-1:0] cfg_data,
  lfsb_in_if.sink                         in_ch,
  lfsb_out_if.source                      out_ch
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = (9 > $clog2(MAX_LEDS + 1)) ? 9 : $clog2(MAX_LEDS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_RUN   = 3'b010,
    ST_FILL  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [8:0] led_count;
  logic       stop_zero_bits;
  logic [CW-1:0] count;

  logic [AW-1:0] sweep_idx;
  logic [lfsb_pkg::ENTRY_W-1:0] fill_entry;
  logic [lfsb_pkg::ENTRY_W-1:0] in_entry;
  logic [CW-1:0] idx_ext;

  logic accept, out_free, p_move;
  logic is_set_one, is_set_all, is_fetch, idx_ok;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [lfsb_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [lfsb_pkg::ENTRY_W-1:0] ram_rdata;

  lfsb_pkg::word_info_t fetch_info;

  logic                 p_valid;
  logic                 p_status;
  logic                 p_last;
  lfsb_pkg::word_sel_t  p_sel;
  logic                 o_valid;
  logic                 o_status;
  logic                 o_last;
  logic [lfsb_pkg::WORD_W-1:0] o_word;
  logic [lfsb_pkg::WORD_W-1:0] p_word;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count      <= '0;
      stop_zero_bits <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfsb_pkg::CFG_LED_COUNT:      led_count <= cfg_data;
        lfsb_pkg::CFG_STOP_ZERO_BITS: stop_zero_bits <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign count = (CW'(led_count) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(led_count);

  assign in_entry   = {in_ch.brightness, in_ch.blue, in_ch.green, in_ch.red};
  assign idx_ext    = CW'(in_ch.led_index);
  assign idx_ok     = idx_ext < count;
  assign out_free   = !o_valid || out_ch.ready;
  assign p_move     = p_valid && out_free;
  assign in_ch.ready = (state == ST_RUN) && (!p_valid || out_free);
  assign accept     = in_ch.valid && in_ch.ready;
  assign is_set_one = accept && (in_ch.cmd == lfsb_pkg::CMD_SET_ONE);
  assign is_set_all = accept && (in_ch.cmd == lfsb_pkg::CMD_SET_ALL);
  assign is_fetch   = accept && (in_ch.cmd == lfsb_pkg::CMD_FETCH);

  // Sequencer: clearing pass, set-all sweep, normal operation.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = sweep_idx;
    ram_wdata  = fill_entry;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (sweep_idx == AW'(MAX_LEDS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if ((CW'(sweep_idx) + CW'(1)) == count) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ram_we    = is_set_one && idx_ok;
        ram_waddr = idx_ext[AW-1:0];
        ram_wdata = in_entry;
        if (is_set_all && (count != '0)) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep_idx <= '0;
    end else begin
      state <= state_next;
      if (state != ST_RUN) begin
        sweep_idx <= (state_next == ST_RUN) ? '0 : sweep_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_set_all) begin
      fill_entry <= in_entry;
    end
  end

  lfsb_stream_ctrl #(
    .MAX_LEDS(MAX_LEDS)
  ) u_stream_ctrl (
    .clk            (clk),
    .rst            (rst),
    .fetch          (is_fetch),
    .stop_zero_bits (stop_zero_bits),
    .count          (count),
    .info           (fetch_info),
    .rd_addr        (ram_raddr)
  );

  lfsb_ram #(
    .WIDTH(lfsb_pkg::ENTRY_W),
    .DEPTH(MAX_LEDS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (is_fetch),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pending stage waits for the memory read; output register feeds the channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (accept) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (p_move) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status <= is_set_one && !idx_ok;
      p_last   <= is_fetch && fetch_info.last;
      p_sel    <= is_fetch ? fetch_info.sel : lfsb_pkg::WSEL_ZERO;
    end
  end

  always_comb begin
    unique case (p_sel)
      lfsb_pkg::WSEL_MEM:  p_word = {lfsb_pkg::HDR_MARK, ram_rdata};
      lfsb_pkg::WSEL_ONES: p_word = '1;
      default:             p_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_status <= p_status;
      o_last   <= p_last;
      o_word   <= p_word;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.status      = o_status;
  assign out_ch.stream_word = o_word;
  assign out_ch.last_word   = o_last;

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !in_ch.ready)
    else $error("item accepted during memory sweep");

  a_accept_fills_pending: assert property (@(posedge clk) disable iff (rst)
    accept |=> p_valid)
    else $error("accepted item lost before pending stage");

  a_last_is_stop: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_word) |->
      ((out_ch.stream_word == '0) || (out_ch.stream_word == '1)))
    else $error("last word is not a stop word");

  a_error_word_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == lfsb_pkg::STATUS_BAD_INDEX)) |->
      ((out_ch.stream_word == '0) && !out_ch.last_word))
    else $error("error result carries stream data");

endmodule

>>> rtl/lfsb_ram.sv
// Generic simple dual-port RAM with registered read.
module lfsb_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lfsb_stream_ctrl.sv
// Stream position tracking and word selection for fetch items.
module lfsb_stream_ctrl #(
  parameter int MAX_LEDS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fetch,
  input  logic                    stop_zero_bits,
  input  logic [((9 > $clog2(MAX_LEDS + 1)) ? 9 : $clog2(MAX_LEDS + 1))-1:0] count,
  output lfsb_pkg::word_info_t    info,
  output logic [(MAX_LEDS > 1 ? $clog2(MAX_LEDS) : 1)-1:0] rd_addr
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = (9 > $clog2(MAX_LEDS + 1)) ? 9 : $clog2(MAX_LEDS + 1);
  localparam int PW = $clog2(MAX_LEDS + MAX_LEDS / 32 + 3);
  localparam int SW = (PW > CW) ? PW : CW;

  logic [SW-1:0] stream_position;
  logic [SW-1:0] count_w;
  logic [SW-1:0] total;
  logic [SW-1:0] pos;
  logic [SW-1:0] pos_plus;
  logic [SW-1:0] pos_minus;

  always_comb begin
    count_w   = SW'(count);
    total     = count_w + (count_w >> 5) + SW'(2);
    pos       = (stream_position >= total) ? '0 : stream_position;
    pos_plus  = pos + SW'(1);
    pos_minus = pos - SW'(1);
    rd_addr   = pos_minus[AW-1:0];
    info.last = (pos_plus == total);
    if (pos == '0) begin
      info.sel = lfsb_pkg::WSEL_ZERO;
    end else if (pos <= count_w) begin
      info.sel = lfsb_pkg::WSEL_MEM;
    end else if (stop_zero_bits) begin
      info.sel = lfsb_pkg::WSEL_ZERO;
    end else begin
      info.sel = lfsb_pkg::WSEL_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_position <= '0;
    end else if (fetch) begin
      stream_position <= info.last ? '0 : pos_plus;
    end
  end

endmodule

>>> verif/lfsb_stream_check.sv
`timescale 1ns / 1ps
// Checker for the LED frame stream builder: tracks the frame store, predicts and compares results.
module lfsb_stream_check
  import lfsb_pkg::*;
#(
  parameter int MAX_LEDS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lfsb_in_if                    in_ch,
  lfsb_out_if                   out_ch,
  output int                    errors,
  output int                    pending,
  output int                    results_seen,
  output int                    streams_done
);

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] word;
    logic              last;
  } led_result_t;

  led_result_t        expected_results[$];
  logic [ENTRY_W-1:0] led_frames[MAX_LEDS];
  int unsigned        word_pos;
  logic [8:0]         chain_len;
  logic               stop_low;

  function automatic led_result_t next_result(input logic [1:0] cmd, input logic [7:0] idx,
                                              input logic [ENTRY_W-1:0] entry);
    int unsigned active;
    int unsigned total;
    int unsigned at;
    int          i;
    led_result_t res;
    res    = '0;
    active = (chain_len > MAX_LEDS) ? MAX_LEDS : chain_len;
    case (cmd)
      CMD_SET_ONE: begin
        if (idx < active) led_frames[idx] = entry;
        else res.status = STATUS_BAD_INDEX;
      end
      CMD_SET_ALL: begin
        for (i = 0; i < active; i++) led_frames[i] = entry;
      end
      CMD_FETCH: begin
        total = 2 + active + active / 32;
        // position left past the end by a shorter chain restarts the stream
        at = (word_pos >= total) ? 0 : word_pos;
        if (at == 0) res.word = '0;
        else if (at <= active) res.word = {HDR_MARK, led_frames[at-1]};
        else res.word = stop_low ? '0 : '1;
        if (at + 1 == total) begin
          res.last = 1'b1;
          word_pos = 0;
        end else begin
          word_pos = at + 1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    led_result_t want;
    if (rst) begin
      expected_results.delete();
      foreach (led_frames[i]) led_frames[i] = '0;
      word_pos  = 0;
      chain_len = '0;
      stop_low  = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LED_COUNT:      chain_len = cfg_data;
          CFG_STOP_ZERO_BITS: stop_low  = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: stream_word %h status %b last_word %b",
                 out_ch.stream_word, out_ch.status, out_ch.last_word);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %b, got %b", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.stream_word !== want.word) begin
            $error("stream_word: expected %h, got %h", want.word, out_ch.stream_word);
            errors++;
          end
          if (out_ch.last_word !== want.last) begin
            $error("last_word: expected %b, got %b", want.last, out_ch.last_word);
            errors++;
          end
          if (want.last) streams_done++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(next_result(in_ch.cmd, in_ch.led_index,
          {in_ch.brightness, in_ch.blue, in_ch.green, in_ch.red}));
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> verif/led_frame_stream_builder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the LED frame stream builder: clock, reset, stimulus and verdict.
module led_frame_stream_builder_tb;
  import lfsb_pkg::*;

  localparam int          MAX_LEDS     = 256;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned GAP_PCT      = 19;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          NUM_PHASES   = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int          items_sent = 0;
  int          reg_writes = 0;
  int          errors;
  int          pending;
  int          results_seen;
  int          streams_done;
  int unsigned phase_counts[NUM_PHASES];

  lfsb_in_if  in_ch ();
  lfsb_out_if out_ch ();

  led_frame_stream_builder #(.MAX_LEDS(MAX_LEDS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lfsb_stream_check #(.MAX_LEDS(MAX_LEDS)) u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .streams_done (streams_done)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #24_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready = no_gaps || ($urandom_range(99) >= GAP_PCT);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] idx, input logic [4:0] br,
                           input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.cmd        = cmd;
    in_ch.led_index  = idx;
    in_ch.brightness = br;
    in_ch.blue       = b;
    in_ch.green      = g;
    in_ch.red        = r;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic fetch_words(input int n);
    repeat (n) send_item(CMD_FETCH, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00);
  endtask

  // registers change only with nothing in flight, a set-all sweep included
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    in_ch.valid = 1'b0;
    while (pending != 0 || in_ch.ready !== 1'b1) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
  endtask

  initial begin
    int          p;
    int          k;
    int unsigned active;
    int unsigned n_items;
    int unsigned fetch_pct;
    int unsigned pick;
    logic [1:0]  cmd;
    logic [7:0]  idx;

    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_FETCH;
    in_ch.led_index  = '0;
    in_ch.brightness = '0;
    in_ch.blue       = '0;
    in_ch.green      = '0;
    in_ch.red        = '0;
    phase_counts = '{1, 5, 31, 32, 33, 64, 100, 7, 0, 256, 511, 300};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    write_reg(CFG_LED_COUNT, 9'd4);
    write_reg(CFG_STOP_ZERO_BITS, 9'd1);
    send_item(CMD_SET_ONE, 8'd0, 5'd31, 8'hff, 8'h00, 8'hff);
    send_item(CMD_SET_ONE, 8'd3, 5'd0, 8'h00, 8'hff, 8'h00);
    send_item(CMD_SET_ONE, 8'd4, 5'd21, 8'h5a, 8'ha5, 8'h3c);
    send_item(CMD_SET_ONE, 8'd255, 5'd10, 8'h01, 8'h02, 8'h03);
    send_item(CMD_UNUSED, 8'hff, 5'd31, 8'hff, 8'hff, 8'hff);
    fetch_words(6);
    send_item(CMD_SET_ALL, 8'h00, 5'd31, 8'hff, 8'hff, 8'hff);
    fetch_words(2);
    // shrink below the current position: next fetch restarts
    write_reg(CFG_LED_COUNT, 9'd0);
    fetch_words(2);
    send_item(CMD_SET_ONE, 8'd0, 5'd7, 8'h11, 8'h22, 8'h33);
    send_item(CMD_SET_ALL, 8'h00, 5'd3, 8'h44, 8'h55, 8'h66);
    write_reg(CFG_STOP_ZERO_BITS, 9'd0);
    fetch_words(2);
    // count above capacity saturates
    write_reg(CFG_LED_COUNT, 9'd511);
    send_item(CMD_SET_ONE, 8'd255, 5'd31, 8'h80, 8'h40, 8'h20);
    fetch_words(1);

    // random phases
    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_LED_COUNT, phase_counts[p][CFG_DATA_W-1:0]);
      write_reg(CFG_STOP_ZERO_BITS, CFG_DATA_W'(p[0]));
      active    = (phase_counts[p] > MAX_LEDS) ? MAX_LEDS : phase_counts[p];
      n_items   = (phase_counts[p] == MAX_LEDS) ? 300 : (phase_counts[p] > MAX_LEDS ? 150 : 80);
      fetch_pct = (phase_counts[p] >= MAX_LEDS) ? 88 : 65;
      no_gaps   = (p == 5);
      if (p == 3) hold_req = 1'b1;
      for (k = 0; k < n_items; k++) begin
        pick = $urandom_range(99);
        if (pick < fetch_pct) cmd = CMD_FETCH;
        else begin
          pick = $urandom_range(99);
          if (pick < 60) cmd = CMD_SET_ONE;
          else if (pick < 80) cmd = CMD_SET_ALL;
          else cmd = CMD_UNUSED;
        end
        if (active > 0 && $urandom_range(3) != 0) idx = 8'($urandom_range(active - 1));
        else idx = 8'($urandom_range(255));
        send_item(cmd, idx, 5'($urandom_range(31)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      no_gaps = 1'b0;
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Sent %0d items across %0d register writes; %0d results checked.",
             items_sent, reg_writes, results_seen);
    $display("Chain lengths 0 to 511 with both stop patterns; %0d streams reached their last word.",
             streams_done);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lfsb_pkg.sv
rtl/lfsb_in_if.sv
rtl/lfsb_out_if.sv
rtl/lfsb_ram.sv
rtl/lfsb_stream_ctrl.sv
rtl/led_frame_stream_builder.sv
verif/lfsb_stream_check.sv
verif/led_frame_stream_builder_tb.sv
